### rtl/core/fmam_pkg.sv
// ----------------------------------------------------------------------------
// fmam_pkg
// Shared types, constants and a helper function of the FM/AM baseband
// modulator: register map, reset values, NCO polynomial coefficients and
// the controller-to-datapath command interface.
// ----------------------------------------------------------------------------
package fmam_pkg;

  localparam int PHASE_BITS_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int GAIN_W = 16;
  localparam int STEP_W = 31;
  localparam int CFG_DW = 31;
  localparam int CFG_IW = 2;
  localparam int MUL_W  = 32;
  localparam int X_W    = 31;
  localparam int Q_FRAC = 30;

  localparam logic [CFG_IW-1:0] REG_MOD_MODE   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_AUDIO_GAIN = 2'd1;
  localparam logic [CFG_IW-1:0] REG_PHASE_STEP = 2'd2;

  localparam logic              MODE_RST = 1'b0;
  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd256;
  localparam logic [STEP_W-1:0] STEP_RST = 31'd16106127;

  // Q30 magnitudes of the sin(pi/2 * x) polynomial, signs alternate
  localparam logic [X_W-1:0] COEF_C1 = 31'd1686629713;
  localparam logic [X_W-1:0] COEF_C3 = 31'd693598668;
  localparam logic [X_W-1:0] COEF_C5 = 31'd85569306;
  localparam logic [X_W-1:0] COEF_C7 = 31'd5026995;
  localparam logic [X_W-1:0] COEF_C9 = 31'd172272;

  localparam logic [1:0] HORNER_LAST = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_GAIN_MUL,
    OP_GAIN_WB,
    OP_PH_LO_MUL,
    OP_PH_LO_WB,
    OP_PH_HI_MUL,
    OP_PH_UPD,
    OP_X_SET,
    OP_SQ_MUL,
    OP_SQ_WB,
    OP_HORN_MUL,
    OP_HORN_WB,
    OP_FIN_MUL,
    OP_FIN_WB,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       pass;   // 0: sine, 1: cosine
    logic [1:0] k;      // Horner step
  } dp_cmd_t;

  typedef struct packed {
    logic am;
  } dp_sts_t;

  function automatic logic [X_W-1:0] horner_coef(input logic [1:0] k);
    logic [X_W-1:0] c;
    case (k)
      2'd0:    c = COEF_C7;
      2'd1:    c = COEF_C5;
      2'd2:    c = COEF_C3;
      default: c = COEF_C1;
    endcase
    return c;
  endfunction

endpackage

### rtl/core/fmam_ctrl.sv
// ----------------------------------------------------------------------------
// fmam_ctrl
// Sequencer of the modulator: walks one item through gain, then in FM mode
// phase update and two NCO polynomial passes; owns input/output handshakes.
// ----------------------------------------------------------------------------
module fmam_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  fmam_pkg::dp_sts_t sts,
  output fmam_pkg::dp_cmd_t cmd
);

  typedef enum logic [14:0] {
    ST_IDLE     = 15'h0001,
    ST_GAIN_MUL = 15'h0002,
    ST_GAIN_WB  = 15'h0004,
    ST_PH_LO    = 15'h0008,
    ST_PH_LO_WB = 15'h0010,
    ST_PH_HI    = 15'h0020,
    ST_PH_UPD   = 15'h0040,
    ST_X_SET    = 15'h0080,
    ST_SQ_MUL   = 15'h0100,
    ST_SQ_WB    = 15'h0200,
    ST_HORN_MUL = 15'h0400,
    ST_HORN_WB  = 15'h0800,
    ST_FIN_MUL  = 15'h1000,
    ST_FIN_WB   = 15'h2000,
    ST_OUTPUT   = 15'h4000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] k_r, k_nxt;
  logic       pass_r, pass_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = fmam_pkg::OP_NONE;
    cmd.pass      = pass_r;
    cmd.k         = k_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = fmam_pkg::OP_LOAD;
          state_nxt = ST_GAIN_MUL;
        end
      end
      ST_GAIN_MUL: begin
        cmd.op    = fmam_pkg::OP_GAIN_MUL;
        state_nxt = ST_GAIN_WB;
      end
      ST_GAIN_WB: begin
        cmd.op    = fmam_pkg::OP_GAIN_WB;
        state_nxt = sts.am ? ST_OUTPUT : ST_PH_LO;
      end
      ST_PH_LO: begin
        cmd.op    = fmam_pkg::OP_PH_LO_MUL;
        state_nxt = ST_PH_LO_WB;
      end
      ST_PH_LO_WB: begin
        cmd.op    = fmam_pkg::OP_PH_LO_WB;
        state_nxt = ST_PH_HI;
      end
      ST_PH_HI: begin
        cmd.op    = fmam_pkg::OP_PH_HI_MUL;
        state_nxt = ST_PH_UPD;
      end
      ST_PH_UPD: begin
        cmd.op    = fmam_pkg::OP_PH_UPD;
        pass_nxt  = 1'b0;
        state_nxt = ST_X_SET;
      end
      ST_X_SET: begin
        cmd.op    = fmam_pkg::OP_X_SET;
        state_nxt = ST_SQ_MUL;
      end
      ST_SQ_MUL: begin
        cmd.op    = fmam_pkg::OP_SQ_MUL;
        state_nxt = ST_SQ_WB;
      end
      ST_SQ_WB: begin
        cmd.op    = fmam_pkg::OP_SQ_WB;
        k_nxt     = '0;
        state_nxt = ST_HORN_MUL;
      end
      ST_HORN_MUL: begin
        cmd.op    = fmam_pkg::OP_HORN_MUL;
        state_nxt = ST_HORN_WB;
      end
      ST_HORN_WB: begin
        cmd.op    = fmam_pkg::OP_HORN_WB;
        k_nxt     = k_r + 2'd1;
        state_nxt = (k_r == fmam_pkg::HORNER_LAST) ? ST_FIN_MUL : ST_HORN_MUL;
      end
      ST_FIN_MUL: begin
        cmd.op    = fmam_pkg::OP_FIN_MUL;
        state_nxt = ST_FIN_WB;
      end
      ST_FIN_WB: begin
        cmd.op    = fmam_pkg::OP_FIN_WB;
        pass_nxt  = 1'b1;
        state_nxt = pass_r ? ST_OUTPUT : ST_X_SET;
      end
      ST_OUTPUT: begin
        if (slot_free) begin
          cmd.op        = fmam_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_GAIN_MUL))
    else $error("accepted item did not start the gain multiply");

  a_out_from_output: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUTPUT))
    else $error("result valid raised outside the output state");

  a_horner_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN_MUL) |-> ($past(k_r) == fmam_pkg::HORNER_LAST))
    else $error("final multiply reached before all Horner steps");

  a_output_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUTPUT && out_valid_r && !out_ready) |=> (state_r == ST_OUTPUT))
    else $error("pending result overwritten");

endmodule

### rtl/core/fmam_datapath.sv
// ----------------------------------------------------------------------------
// fmam_datapath
// Configuration registers, phase accumulator and one shared 32x32 multiplier
// with product register; each controller op selects operands or a write-back.
// ----------------------------------------------------------------------------
module fmam_datapath #(
  parameter int PHASE_BITS  = fmam_pkg::PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = fmam_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [fmam_pkg::CFG_IW-1:0]         cfg_idx,
  input  logic [fmam_pkg::CFG_DW-1:0]         cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0]       in_audio_sample,
  input  fmam_pkg::dp_cmd_t                   cmd,
  output fmam_pkg::dp_sts_t                   sts,
  output logic signed [SAMPLE_BITS-1:0]       out_i_out,
  output logic signed [SAMPLE_BITS-1:0]       out_q_out
);

  localparam int PB     = PHASE_BITS;
  localparam int SB     = SAMPLE_BITS;
  localparam int MW     = fmam_pkg::MUL_W;
  localparam int XW     = fmam_pkg::X_W;
  localparam int QF     = fmam_pkg::Q_FRAC;
  localparam int GW     = fmam_pkg::GAIN_W;
  localparam int SW     = fmam_pkg::STEP_W;
  localparam int ACC_W  = SB + SW;
  localparam int PMAG_W = SB + GW - 8;
  localparam int FOLD_W = PB - 2 + QF;

  localparam logic [PMAG_W-1:0] HALF   = PMAG_W'(1) << (SB - 1);
  localparam logic [PB-1:0]     QTR    = PB'(1) << (PB - 2);
  localparam logic [XW-1:0]     X_ONE  = XW'(1) << QF;
  localparam logic [MW-1:0]     RND    = MW'(1) << (QF - SB);
  localparam logic [MW-1:0]     FULL_P = (MW'(1) << (SB - 1)) - MW'(1);

  logic                 mode_r;
  logic [GW-1:0]        gain_r;
  logic [SW-1:0]        step_r;
  logic [PB-1:0]        phase_r;
  logic [SB-1:0]        mag_r;
  logic                 neg_r;
  logic [SB-1:0]        amag_r;
  logic [2*MW-1:0]      prod_r;
  logic [ACC_W-1:0]     acc_r;
  logic [XW-1:0]        x_r;
  logic [1:0]           quad_r;
  logic [XW-1:0]        x2_r;
  logic [XW-1:0]        t_r;
  logic signed [SB-1:0] res_i_r;
  logic signed [SB-1:0] res_q_r;
  logic signed [SB-1:0] out_i_r;
  logic signed [SB-1:0] out_q_r;

  logic [MW-1:0]        mul_a, mul_b;
  logic [2*MW-1:0]      prod_nxt;
  logic [PMAG_W-1:0]    pmag, lim;
  logic [SB-1:0]        amag_nxt;
  logic [SB-1:0]        mag_nxt;
  logic [ACC_W-1:0]     ph_sum;
  logic [PB+ACC_W-1:0]  ph_wide;
  logic [PB-1:0]        ph_d;
  logic [PB-1:0]        phase_nxt;
  logic [PB-1:0]        ph_sel;
  logic [FOLD_W-1:0]    fold_wide;
  logic [XW-1:0]        x0, x_nxt;
  logic [XW-1:0]        prod_q;
  logic [MW-1:0]        rnd_sum, rnd_val;
  logic [SB-1:0]        trig_mag;
  logic signed [SB-1:0] trig_val;

  assign sts.am    = mode_r;
  assign out_i_out = out_i_r;
  assign out_q_out = out_q_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      fmam_pkg::OP_GAIN_MUL: begin
        mul_a = MW'(mag_r);
        mul_b = MW'(gain_r);
      end
      fmam_pkg::OP_PH_LO_MUL: begin
        mul_a = MW'(amag_r);
        mul_b = MW'(step_r[15:0]);
      end
      fmam_pkg::OP_PH_HI_MUL: begin
        mul_a = MW'(amag_r);
        mul_b = MW'(step_r[SW-1:16]);
      end
      fmam_pkg::OP_SQ_MUL: begin
        mul_a = MW'(x_r);
        mul_b = MW'(x_r);
      end
      fmam_pkg::OP_HORN_MUL: begin
        mul_a = MW'(x2_r);
        mul_b = MW'(t_r);
      end
      fmam_pkg::OP_FIN_MUL: begin
        mul_a = MW'(x_r);
        mul_b = MW'(t_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = (2*MW)'(mul_a) * (2*MW)'(mul_b);
  assign prod_q   = prod_r[QF+XW-1:QF];

  // gain and clip, truncating toward zero
  assign mag_nxt  = in_audio_sample[SB-1] ? SB'(-in_audio_sample) : SB'(in_audio_sample);
  assign pmag     = prod_r[SB+GW-1:8];
  assign lim      = neg_r ? HALF : (HALF - PMAG_W'(1));
  assign amag_nxt = (pmag > lim) ? lim[SB-1:0] : pmag[SB-1:0];

  // phase increment
  assign ph_sum    = acc_r + {prod_r[ACC_W-17:0], 16'b0};
  assign ph_wide   = {{PB{1'b0}}, ph_sum} >> (SB - 1);
  assign ph_d      = ph_wide[PB-1:0];
  assign phase_nxt = neg_r ? (phase_r - ph_d) : (phase_r + ph_d);

  // quarter-wave fold to Q30
  assign ph_sel    = cmd.pass ? (phase_r + QTR) : phase_r;
  assign fold_wide = {ph_sel[PB-3:0], {QF{1'b0}}} >> (PB - 2);
  assign x0        = {1'b0, fold_wide[QF-1:0]};
  assign x_nxt     = ph_sel[PB-2] ? (X_ONE - x0) : x0;

  // round to output format and saturate
  assign rnd_sum  = MW'(prod_q) + RND;
  assign rnd_val  = rnd_sum >> (QF + 1 - SB);
  assign trig_mag = (rnd_val > FULL_P) ? FULL_P[SB-1:0] : rnd_val[SB-1:0];
  assign trig_val = quad_r[1] ? $signed(-trig_mag) : $signed(trig_mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= fmam_pkg::MODE_RST;
      gain_r  <= fmam_pkg::GAIN_RST;
      step_r  <= fmam_pkg::STEP_RST;
      phase_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          fmam_pkg::REG_MOD_MODE:   mode_r <= cfg_wdata[0];
          fmam_pkg::REG_AUDIO_GAIN: gain_r <= cfg_wdata[GW-1:0];
          fmam_pkg::REG_PHASE_STEP: step_r <= cfg_wdata[SW-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.op == fmam_pkg::OP_PH_UPD) begin
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    case (cmd.op)
      fmam_pkg::OP_LOAD: begin
        mag_r <= mag_nxt;
        neg_r <= in_audio_sample[SB-1];
      end
      fmam_pkg::OP_GAIN_WB: begin
        amag_r  <= amag_nxt;
        res_i_r <= neg_r ? $signed(-amag_nxt) : $signed(amag_nxt);
        res_q_r <= '0;
      end
      fmam_pkg::OP_PH_LO_WB: begin
        acc_r <= prod_r[ACC_W-1:0];
      end
      fmam_pkg::OP_X_SET: begin
        x_r    <= x_nxt;
        quad_r <= ph_sel[PB-1:PB-2];
      end
      fmam_pkg::OP_SQ_WB: begin
        x2_r <= prod_q;
        t_r  <= fmam_pkg::COEF_C9;
      end
      fmam_pkg::OP_HORN_WB: begin
        t_r <= fmam_pkg::horner_coef(cmd.k) - prod_q;
      end
      fmam_pkg::OP_FIN_WB: begin
        if (cmd.pass) begin
          res_q_r <= trig_val;
        end else begin
          res_i_r <= trig_val;
        end
      end
      fmam_pkg::OP_OUT: begin
        out_i_r <= res_i_r;
        out_q_r <= res_q_r;
      end
      default: begin
      end
    endcase
  end

  a_am_q_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == fmam_pkg::OP_GAIN_WB && mode_r) |=> (res_q_r == '0))
    else $error("AM quadrature result not zero");

endmodule

### rtl/core/fm_am_baseband_modulator.sv
// ----------------------------------------------------------------------------
// fm_am_baseband_modulator
// FM/AM baseband modulator: gain and clip of each audio item, then either the
// clipped amplitude (AM) or sine/cosine of a wrapping phase accumulator (FM).
//
//   channel  dir  handshake             payload
//   in       in   in_valid/in_ready     in_audio_sample
//   out      out  out_valid/out_ready   out_i_out, out_q_out
//   cfg      in   cfg_we                cfg_idx, cfg_wdata
//
// One item at a time on a single shared 32x32 multiplier; every product has
// a multiply state and a write-back state. AM items take the gain only; FM
// items take gain, two-part phase product and two degree-9 NCO passes.
// Reset (synchronous) zeroes the phase and loads register defaults.
// A finished result waits in the output register; a new item is accepted
// meanwhile, and the sequencer stalls only if the next result is ready first.
// ----------------------------------------------------------------------------
module fm_am_baseband_modulator #(
  parameter int PHASE_BITS  = fmam_pkg::PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = fmam_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fmam_pkg::CFG_IW-1:0]   cfg_idx,
  input  logic [fmam_pkg::CFG_DW-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_audio_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_i_out,
  output logic signed [SAMPLE_BITS-1:0] out_q_out
);

  fmam_pkg::dp_cmd_t cmd;
  fmam_pkg::dp_sts_t sts;

  fmam_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fmam_datapath #(
    .PHASE_BITS  (PHASE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .in_audio_sample (in_audio_sample),
    .cmd             (cmd),
    .sts             (sts),
    .out_i_out       (out_i_out),
    .out_q_out       (out_q_out)
  );

endmodule
